// File: sv/set_assoc_lru_cache_model_defines.svh
// assertion macros for the set-associative lru cache model
// no dependencies; included by the modules that carry concurrent checks
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slc check failed");
`define SLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slc check failed");
`else
`define SLC_ASSERT_NOW(label, clk, rst, ante, cons)
`define SLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/slc_pkg.sv
// shared types and codes for the set-associative lru cache model
// no dependencies; used by the interfaces and modules of the block
package slc_pkg;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int CNT_W  = 32;
  localparam int REG_IW = 2;

  // access kinds
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_IFETCH = 2'd3;

  // lookup outcomes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  // register indexes
  localparam logic [REG_IW-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [REG_IW-1:0] REG_WAYS       = 2'd1;
  localparam logic [REG_IW-1:0] REG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways;
    logic [4:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic       done;
    logic [1:0] outcome;
  } scan_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

// File: sv/slc_req_if.sv
// request channel: valid/ready handshake carrying one cache access
// depends on slc_pkg for field widths
interface slc_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [slc_pkg::ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink (input valid, input op, input address, output ready);
endinterface

// File: sv/slc_rsp_if.sv
// result channel: valid/ready handshake carrying outcomes and counters
// depends on slc_pkg for field widths
interface slc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                first_outcome;
  logic [1:0]                second_outcome;
  logic [slc_pkg::CNT_W-1:0] hit_total;
  logic [slc_pkg::CNT_W-1:0] miss_total;
  logic [slc_pkg::CNT_W-1:0] eviction_total;

  modport source (output valid, output first_outcome, output second_outcome,
                  output hit_total, output miss_total, output eviction_total,
                  input ready);
  modport sink (input valid, input first_outcome, input second_outcome,
                input hit_total, input miss_total, input eviction_total,
                output ready);
endinterface

// File: sv/slc_cfg_regs.sv
// apb configuration registers: set_bits, ways, block_bits
// depends on slc_pkg; raises clear on every write to a known register
module slc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slc_pkg::APB_AW-1:0]  paddr,
  input  logic [slc_pkg::APB_DW-1:0]  pwdata,
  output logic [slc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output slc_pkg::cfg_t               cfg,
  output logic                        clear
);

  logic                        wr;
  logic [slc_pkg::REG_IW-1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[slc_pkg::APB_AW-1:2];

  always_comb begin
    case (idx)
      slc_pkg::REG_SET_BITS, slc_pkg::REG_WAYS, slc_pkg::REG_BLOCK_BITS: clear = wr;
      default: clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits   <= 3'd0;
      cfg.ways       <= 4'd1;
      cfg.block_bits <= 5'd0;
    end else if (wr) begin
      case (idx)
        slc_pkg::REG_SET_BITS:   cfg.set_bits   <= pwdata[2:0];
        slc_pkg::REG_WAYS:       cfg.ways       <= pwdata[3:0];
        slc_pkg::REG_BLOCK_BITS: cfg.block_bits <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      slc_pkg::REG_SET_BITS:   prdata = {{(slc_pkg::APB_DW-3){1'b0}}, cfg.set_bits};
      slc_pkg::REG_WAYS:       prdata = {{(slc_pkg::APB_DW-4){1'b0}}, cfg.ways};
      slc_pkg::REG_BLOCK_BITS: prdata = {{(slc_pkg::APB_DW-5){1'b0}}, cfg.block_bits};
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: sv/slc_tag_ram.sv
// set row memory: one row per set holding valid, tag and rank of every way
// depends on slc_pkg; per-row ok bits make unwritten rows read as empty
module slc_tag_ram #(
  parameter int  MAX_SET_BITS = 6,
  parameter int  MAX_WAYS     = 8,
  localparam int SET_IW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int ENT_W        = 1 + slc_pkg::TAG_W + RANK_W,
  localparam int ROW_W        = MAX_WAYS * ENT_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     rd_en,
  input  logic [SET_IW-1:0]        rd_addr,
  input  logic                     wr_en,
  input  logic [SET_IW-1:0]        wr_addr,
  input  logic [ROW_W-1:0]         wr_data,
  output logic [ROW_W-1:0]         rd_row
);

  localparam int ROWS   = 2 ** MAX_SET_BITS;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_q;
  logic [ROWS-1:0]  row_ok;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_ok <= '0;
    end else if (wr_en) begin
      row_ok[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (rd_en) begin
      rd_ok <= row_ok[rd_addr];
    end
  end

  // a row never written since the last invalidate reads as all ways empty
  assign rd_row = rd_ok ? rd_q : '0;

endmodule

// File: sv/slc_way_scan.sv
// way scanner: one tag compare and one rank compare, one way per cycle
// depends on slc_pkg and the assertion macro header
`include "set_assoc_lru_cache_model_defines.svh"
module slc_way_scan #(
  parameter int  MAX_WAYS = 8,
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int NW_W     = $clog2(MAX_WAYS + 1),
  localparam int ENT_W    = 1 + slc_pkg::TAG_W + RANK_W,
  localparam int ROW_W    = MAX_WAYS * ENT_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NW_W-1:0]            nw,
  input  logic [slc_pkg::TAG_W-1:0]  tag,
  input  logic [ROW_W-1:0]           row,
  output slc_pkg::scan_stat_t        stat,
  output logic [WAY_IW-1:0]          way
);

  logic                      busy;
  logic                      done_q;
  logic [1:0]                outcome_q;
  logic [WAY_IW-1:0]         way_q;
  logic [WAY_IW-1:0]         idx;
  logic [WAY_IW-1:0]         victim;
  logic [RANK_W-1:0]         oldest;
  logic [ENT_W-1:0]          ent;
  logic                      e_valid;
  logic [slc_pkg::TAG_W-1:0] e_tag;
  logic [RANK_W-1:0]         e_rank;
  logic                      last;
  logic                      cand;
  logic                      finish;

  always_comb begin
    ent     = row[idx*ENT_W +: ENT_W];
    e_valid = ent[ENT_W-1];
    e_tag   = ent[ENT_W-2 -: slc_pkg::TAG_W];
    e_rank  = ent[RANK_W-1:0];
    last    = (NW_W'(idx) + NW_W'(1)) == nw;
    // first way seeds the oldest search
    cand    = (idx == '0) || (e_rank > oldest);
    finish  = !e_valid || (e_tag == tag) || last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && finish;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
    end else if (busy) begin
      if (!e_valid) begin
        outcome_q <= slc_pkg::OUT_MISS;
        way_q     <= idx;
      end else if (e_tag == tag) begin
        outcome_q <= slc_pkg::OUT_HIT;
        way_q     <= idx;
      end else begin
        if (cand) begin
          oldest <= e_rank;
          victim <= idx;
        end
        if (last) begin
          outcome_q <= slc_pkg::OUT_EVICT;
          way_q     <= cand ? idx : victim;
        end else begin
          idx <= idx + WAY_IW'(1);
        end
      end
    end
  end

  assign stat.done    = done_q;
  assign stat.outcome = outcome_q;
  assign way          = way_q;

  `SLC_ASSERT_NOW(a_start_idle, clk, rst, start, !busy)
  `SLC_ASSERT_NOW(a_done_stops, clk, rst, done_q, !busy)
  `SLC_ASSERT_NOW(a_done_outcome, clk, rst, done_q, outcome_q != slc_pkg::OUT_NONE)
  `SLC_ASSERT_NOW(a_way_in_range, clk, rst, done_q, NW_W'(way_q) < nw)

endmodule

// File: sv/set_assoc_lru_cache_model.sv
// Tag model of a set-associative cache with least-recently-used replacement.
// Each request is one access: load and store do one lookup, modify does two
// lookups of the same address, instruction fetch does none. The address is
// shifted right by block_bits; the low set_bits bits pick the set and the
// rest is the tag. A lookup hits, fills the first empty way, or evicts the
// least recently used way. Every request gives exactly one result holding
// both outcomes (3 where no lookup took place) and saturating hit, miss and
// eviction totals. Writing any configuration register empties the cache and
// keeps the totals. The user must write registers only while the block is
// idle; the block itself does not enforce it. Timing: a lookup reads its
// set row from the row memory, then a single shared tag/rank comparator
// walks the ways one per cycle until it finds a hit, an empty way or the
// last way, then the updated row is written back. Results wait in an
// output register while the block accepts the next request; a stalled
// result holds the sequencer only at its last step. The cache starts
// empty right after reset: each set row carries an ok bit cleared at once,
// no clearing pass.
// Depends on slc_pkg, the channel interfaces, slc_cfg_regs, slc_tag_ram and
// slc_way_scan.
`include "set_assoc_lru_cache_model_defines.svh"
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  slc_req_if.sink                     req,
  slc_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slc_pkg::APB_AW-1:0]  paddr,
  input  logic [slc_pkg::APB_DW-1:0]  pwdata,
  output logic [slc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);
  localparam int ENT_W  = 1 + slc_pkg::TAG_W + RANK_W;
  localparam int ROW_W  = MAX_WAYS * ENT_W;

  slc_pkg::state_t            state;
  slc_pkg::state_t            state_next;
  slc_pkg::cfg_t              cfg;
  slc_pkg::scan_stat_t        scan_stat;
  logic                       cfg_clear;

  // effective configuration after clamping
  logic [2:0]                 sb_eff;
  logic [NW_W-1:0]            nw_eff;

  // request held for the whole sequence
  logic [1:0]                 op_q;
  logic [slc_pkg::ADDR_W-1:0] addr_q;
  logic [SET_IW-1:0]          set_q;
  logic [slc_pkg::TAG_W-1:0]  tag_q;
  logic                       second_q;
  logic [1:0]                 first_out_q;
  logic [1:0]                 second_out_q;

  logic [slc_pkg::ADDR_W-1:0] blk;
  logic [SET_IW-1:0]          set_calc;
  logic [slc_pkg::TAG_W-1:0]  tag_calc;

  // saturating totals
  logic [slc_pkg::CNT_W-1:0]  hits;
  logic [slc_pkg::CNT_W-1:0]  misses;
  logic [slc_pkg::CNT_W-1:0]  evicts;

  // sequencer controls
  logic                       rd_en;
  logic                       wr_en;
  logic                       scan_start;
  logic                       out_load;
  logic                       out_valid;

  logic [ROW_W-1:0]           row_rd;
  logic [ROW_W-1:0]           row_new;
  logic [WAY_IW-1:0]          scan_way;
  logic [RANK_W-1:0]          hit_rank;
  logic [ENT_W-1:0]           ent;

  slc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (cfg_clear)
  );

  slc_tag_ram #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_clear),
    .rd_en   (rd_en),
    .rd_addr (set_q),
    .wr_en   (wr_en),
    .wr_addr (set_q),
    .wr_data (row_new),
    .rd_row  (row_rd)
  );

  slc_way_scan #(
    .MAX_WAYS (MAX_WAYS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .nw    (nw_eff),
    .tag   (tag_q),
    .row   (row_rd),
    .stat  (scan_stat),
    .way   (scan_way)
  );

  // clamp set bits and way count to what the hardware holds
  always_comb begin
    sb_eff = ({1'b0, cfg.set_bits} > 4'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : cfg.set_bits;
    if (cfg.ways == 4'd0) begin
      nw_eff = NW_W'(1);
    end else if ({1'b0, cfg.ways} > 5'(MAX_WAYS)) begin
      nw_eff = NW_W'(MAX_WAYS);
    end else begin
      nw_eff = NW_W'(cfg.ways);
    end
  end

  // address split: drop block offset, low bits pick the set, rest is the tag
  always_comb begin
    blk      = addr_q >> cfg.block_bits;
    set_calc = SET_IW'(blk) & ~({SET_IW{1'b1}} << sb_eff);
    tag_calc = slc_pkg::TAG_W'({32'd0, addr_q} >> (6'(cfg.block_bits) + 6'(sb_eff)));
  end

  // row update: chosen way becomes most recent, younger valid ways age by one
  // (a hit ages only ways more recent than it, a fill or eviction ages all)
  always_comb begin
    row_new  = row_rd;
    hit_rank = row_rd[scan_way*ENT_W +: RANK_W];
    for (int j = 0; j < MAX_WAYS; j++) begin
      ent = row_rd[j*ENT_W +: ENT_W];
      if (WAY_IW'(j) == scan_way) begin
        ent = {1'b1, tag_q, {RANK_W{1'b0}}};
      end else if (ent[ENT_W-1] &&
                   ((scan_stat.outcome != slc_pkg::OUT_HIT) || (ent[RANK_W-1:0] < hit_rank))) begin
        ent[RANK_W-1:0] = ent[RANK_W-1:0] + RANK_W'(1);
      end
      row_new[j*ENT_W +: ENT_W] = ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      slc_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          // instruction fetch skips straight to the result
          state_next = (req.op == slc_pkg::OP_IFETCH) ? slc_pkg::ST_FINISH : slc_pkg::ST_SPLIT;
        end
      end
      slc_pkg::ST_SPLIT: begin
        state_next = slc_pkg::ST_READ;
      end
      slc_pkg::ST_READ: begin
        // row data lands as the scan takes its first way
        rd_en      = 1'b1;
        scan_start = 1'b1;
        state_next = slc_pkg::ST_SCAN;
      end
      slc_pkg::ST_SCAN: begin
        if (scan_stat.done) begin
          state_next = slc_pkg::ST_WRITE;
        end
      end
      slc_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        // modify reruns the lookup against the row just written
        if ((op_q == slc_pkg::OP_MODIFY) && !second_q) begin
          state_next = slc_pkg::ST_READ;
        end else begin
          state_next = slc_pkg::ST_FINISH;
        end
      end
      slc_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = slc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slc_pkg::ST_IDLE;
      end
    endcase
  end

  // request capture, address split and per-pass outcomes
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q         <= req.op;
      addr_q       <= req.address;
      first_out_q  <= slc_pkg::OUT_NONE;
      second_out_q <= slc_pkg::OUT_NONE;
    end
    if (state == slc_pkg::ST_SPLIT) begin
      set_q <= set_calc;
      tag_q <= tag_calc;
    end
    if (wr_en) begin
      if (second_q) begin
        second_out_q <= scan_stat.outcome;
      end else begin
        first_out_q <= scan_stat.outcome;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_q <= 1'b0;
    end else if (req.valid && req.ready) begin
      second_q <= 1'b0;
    end else if (wr_en) begin
      second_q <= 1'b1;
    end
  end

  // totals, each stuck at all ones once full
  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      misses <= '0;
      evicts <= '0;
    end else if (wr_en) begin
      if (scan_stat.outcome == slc_pkg::OUT_HIT) begin
        if (hits != '1) begin
          hits <= hits + slc_pkg::CNT_W'(1);
        end
      end else begin
        if (misses != '1) begin
          misses <= misses + slc_pkg::CNT_W'(1);
        end
        if ((scan_stat.outcome == slc_pkg::OUT_EVICT) && (evicts != '1)) begin
          evicts <= evicts + slc_pkg::CNT_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.first_outcome  <= first_out_q;
      rsp.second_outcome <= second_out_q;
      rsp.hit_total      <= hits;
      rsp.miss_total     <= misses;
      rsp.eviction_total <= evicts;
    end
  end

  assign rsp.valid = out_valid;

  `SLC_ASSERT_NOW(a_done_in_scan, clk, rst, scan_stat.done, state == slc_pkg::ST_SCAN)
  `SLC_ASSERT_NEXT(a_modify_rerun, clk, rst, wr_en && (op_q == slc_pkg::OP_MODIFY) && !second_q, state == slc_pkg::ST_READ)
  `SLC_ASSERT_NEXT(a_fetch_skips, clk, rst, req.valid && req.ready && (req.op == slc_pkg::OP_IFETCH), state == slc_pkg::ST_FINISH)
  `SLC_ASSERT_NEXT(a_hits_grow, clk, rst, 1'b1, hits >= $past(hits))

endmodule
